/* src/winnowing_fingerprint_selector_assert.svh */
// -----------------------------------------------------------------------------
// winnowing_fingerprint_selector_assert.svh
// Assertion macros shared by the fingerprint selector checks.
// -----------------------------------------------------------------------------
`ifndef WINNOWING_FINGERPRINT_SELECTOR_ASSERT_SVH
`define WINNOWING_FINGERPRINT_SELECTOR_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define WFS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wfs check failed");

// next-cycle implication, sampled on clock, off during reset
`define WFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wfs check failed");

`endif

/* src/wfs_pkg.sv */
// -----------------------------------------------------------------------------
// wfs_pkg
// Types and fixed widths of the winnowing fingerprint selector.
// -----------------------------------------------------------------------------
package wfs_pkg;

   localparam int HASH_BITS = 32;
   localparam int POS_BITS  = 24;
   localparam int CFG_BITS  = 7;

   localparam logic [CFG_BITS-1:0] WIN_RESET = 7'd40;

   // input transfer payload
   typedef struct packed {
      logic [HASH_BITS-1:0] gram_hash;
      logic                 new_text;
   } wfs_req_type;

   // result transfer payload
   typedef struct packed {
      logic [HASH_BITS-1:0] fp_hash;
      logic [POS_BITS-1:0]  fp_position;
   } wfs_rsp_type;

   // control of the shared minimum unit
   typedef struct packed {
      logic clear;       // drop the running minimum (new text)
      logic take;        // a candidate is offered this cycle
      logic force_load;  // load the candidate without comparing
   } wfs_min_ctl_type;

endpackage

/* src/winnowing_fingerprint_selector.sv */
// -----------------------------------------------------------------------------
// winnowing_fingerprint_selector
// Winnowing sliding-window minimum over a stream of k-gram hashes. Gives a
// fingerprint (hash, position) when the first window of a text fills and
// whenever the selected minimum moves. Rescans the window store when the
// selected minimum ages out of the window.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  wfs_req_type (gram_hash, new_text)
//   rsp      out        rsp_valid / rsp_stall  wfs_rsp_type (fp_hash, fp_position)
//   csr      in         csr_wr_en              csr_wr_data (window_size)
//
// Most items are handled by one compare against the running minimum.
// An item whose minimum leaves the window starts a rescan of the effective
// window size (0 counts as 1, capped at WINDOW_MAX) entries: the window store
// RAM is read one entry per cycle through its single read port.
// Reset is synchronous; no clearing pass, the window store starts unwritten.
// The result register holds a result under rsp_stall; input is taken again
// once that register is free or being drained and no rescan is running.
// -----------------------------------------------------------------------------
module winnowing_fingerprint_selector import wfs_pkg::*; #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wfs_req_type         req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wfs_rsp_type         rsp_data,
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data
);

   localparam int AW   = $clog2(WINDOW_MAX);
   localparam int WB   = $clog2(WINDOW_MAX + 1);
   localparam int CMPW = (WB > CFG_BITS) ? WB : CFG_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FIN   = 4'b1000
   } wfs_state_type;

   wfs_state_type state_ff, state_in;

   logic [CFG_BITS-1:0] win_cfg_ff, win_cfg_in;
   logic [POS_BITS-1:0] count_ff, count_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic                emitted_ff, emitted_in;
   logic [POS_BITS-1:0] last_ff, last_in;
   logic [AW-1:0]       scan_a_ff, scan_a_in;
   logic [AW-1:0]       scan_base_ff, scan_base_in;
   logic [POS_BITS-1:0] issue_pos_ff, issue_pos_in;
   logic                scan_first_ff, scan_first_in;
   logic                rd_pending_ff, rd_pending_in;
   logic                rd_first_ff, rd_first_in;
   logic [POS_BITS-1:0] rd_pos_ff, rd_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wfs_rsp_type         rsp_data_ff, rsp_data_in;

   logic [CMPW-1:0]     cfg_ext;
   logic [CMPW-1:0]     win_sel;
   logic [WB-1:0]       win;
   logic [WB-1:0]       win_m1_full;
   logic [AW-1:0]       win_m1;
   logic                accept;
   logic                nt;
   logic [POS_BITS-1:0] eff_count;
   logic [AW-1:0]       eff_slot;
   logic                eff_emitted;
   logic [POS_BITS-1:0] eff_last;
   logic [POS_BITS-1:0] age;
   logic [POS_BITS-1:0] win_pos;
   logic [POS_BITS:0]   count_p1;
   logic                need_scan;
   logic                fill_done;
   logic [AW-1:0]       slot_next;
   logic [AW:0]         scan_idx_full;
   logic [AW-1:0]       scan_idx;

   wfs_min_ctl_type      min_ctl;
   logic [HASH_BITS-1:0] cand_hash;
   logic [POS_BITS-1:0]  cand_pos;
   logic [HASH_BITS-1:0] min_hash;
   logic [POS_BITS-1:0]  min_pos;
   logic [HASH_BITS-1:0] next_hash;
   logic [POS_BITS-1:0]  next_pos;
   logic [HASH_BITS-1:0] rd_data;

   // effective window size: zero acts as one, saturate at the store depth
   always_comb begin
      cfg_ext     = CMPW'(win_cfg_ff);
      if (cfg_ext == '0) begin
         win_sel = CMPW'(1);
      end else if (cfg_ext > CMPW'(WINDOW_MAX)) begin
         win_sel = CMPW'(WINDOW_MAX);
      end else begin
         win_sel = cfg_ext;
      end
      win         = win_sel[WB-1:0];
      win_m1_full = win - WB'(1);
      win_m1      = win_m1_full[AW-1:0];
      win_pos     = {{(POS_BITS-WB){1'b0}}, win};
   end

   // item view after an optional new-text clear
   always_comb begin
      accept      = req_valid & ~req_stall;
      nt          = req_data.new_text;
      eff_count   = nt ? '0 : count_ff;
      eff_slot    = nt ? '0 : slot_ff;
      eff_emitted = nt ? 1'b0 : emitted_ff;
      eff_last    = nt ? '0 : last_ff;
      age         = eff_count - min_pos;
      need_scan   = eff_emitted & (age >= win_pos);
      count_p1    = {1'b0, eff_count} + (POS_BITS+1)'(1);
      fill_done   = count_p1 >= {1'b0, win_pos};
      slot_next   = (eff_slot == AW'(WINDOW_MAX - 1)) ? '0 : eff_slot + AW'(1);
   end

   // read address: slot of the newest item minus the scan offset, modulo depth
   always_comb begin
      scan_idx_full = {1'b0, scan_base_ff}
                    + ((scan_base_ff < scan_a_ff) ? (AW+1)'(WINDOW_MAX) : '0)
                    - {1'b0, scan_a_ff};
      scan_idx      = scan_idx_full[AW-1:0];
   end

   // operand select for the shared minimum unit
   always_comb begin
      min_ctl   = '0;
      cand_hash = req_data.gram_hash;
      cand_pos  = eff_count;
      if (rd_pending_ff) begin
         min_ctl.take       = 1'b1;
         min_ctl.force_load = rd_first_ff;
         cand_hash          = rd_data;
         cand_pos           = rd_pos_ff;
      end else if (accept) begin
         min_ctl.clear      = nt;
         min_ctl.take       = ~need_scan;
         min_ctl.force_load = ~eff_emitted & (eff_count == '0);
      end
   end

   wfs_min_unit u_min (
      .clock     (clock),
      .reset     (reset),
      .ctl       (min_ctl),
      .cand_hash (cand_hash),
      .cand_pos  (cand_pos),
      .min_hash  (min_hash),
      .min_pos   (min_pos),
      .next_hash (next_hash),
      .next_pos  (next_pos)
   );

   wfs_ram #(
      .WIDTH (HASH_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (eff_slot),
      .wr_data (req_data.gram_hash),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (scan_idx),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      win_cfg_in    = csr_wr_en ? csr_wr_data : win_cfg_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      emitted_in    = emitted_ff;
      last_in       = last_ff;
      scan_a_in     = scan_a_ff;
      scan_base_in  = scan_base_ff;
      issue_pos_in  = issue_pos_ff;
      scan_first_in = scan_first_ff;
      rd_pending_in = 1'b0;
      rd_first_in   = rd_first_ff;
      rd_pos_in     = rd_pos_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in   = count_p1[POS_BITS-1:0];
               slot_in    = slot_next;
               emitted_in = eff_emitted;
               last_in    = eff_last;
               if (!eff_emitted) begin
                  // first window of the text still filling
                  if (fill_done) begin
                     emitted_in              = 1'b1;
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.fp_hash     = next_hash;
                     rsp_data_in.fp_position = next_pos;
                     last_in                 = next_pos;
                  end
               end else if (need_scan) begin
                  state_in      = ST_SCAN;
                  scan_a_in     = win_m1;
                  scan_base_in  = eff_slot;
                  issue_pos_in  = eff_count - {{(POS_BITS-AW){1'b0}}, win_m1};
                  scan_first_in = 1'b1;
               end else if (next_pos != eff_last) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.fp_hash     = next_hash;
                  rsp_data_in.fp_position = next_pos;
                  last_in                 = next_pos;
               end
            end
         end
         ST_SCAN: begin
            // one read per cycle, oldest entry first
            rd_pending_in = 1'b1;
            rd_first_in   = scan_first_ff;
            rd_pos_in     = issue_pos_ff;
            issue_pos_in  = issue_pos_ff + POS_BITS'(1);
            scan_first_in = 1'b0;
            if (scan_a_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               scan_a_in = scan_a_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            // last read data is compared this cycle
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (min_pos != last_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.fp_hash     = min_hash;
                  rsp_data_in.fp_position = min_pos;
                  last_in                 = min_pos;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_cfg_ff    <= WIN_RESET;
         count_ff      <= '0;
         slot_ff       <= '0;
         emitted_ff    <= 1'b0;
         last_ff       <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         win_cfg_ff    <= win_cfg_in;
         count_ff      <= count_in;
         slot_ff       <= slot_in;
         emitted_ff    <= emitted_in;
         last_ff       <= last_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // scan and result payload registers
   always_ff @(posedge clock) begin
      scan_a_ff     <= scan_a_in;
      scan_base_ff  <= scan_base_in;
      issue_pos_ff  <= issue_pos_in;
      scan_first_ff <= scan_first_in;
      rd_first_ff   <= rd_first_in;
      rd_pos_ff     <= rd_pos_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/wfs_ram.sv */
// -----------------------------------------------------------------------------
// wfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module wfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/wfs_min_unit.sv */
// -----------------------------------------------------------------------------
// wfs_min_unit
// Running minimum register with the one shared hash comparator. Strict less
// than, so on a tie the older entry stays selected.
// -----------------------------------------------------------------------------
module wfs_min_unit import wfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  wfs_min_ctl_type      ctl,
   input  logic [HASH_BITS-1:0] cand_hash,
   input  logic [POS_BITS-1:0]  cand_pos,
   output logic [HASH_BITS-1:0] min_hash,
   output logic [POS_BITS-1:0]  min_pos,
   output logic [HASH_BITS-1:0] next_hash,
   output logic [POS_BITS-1:0]  next_pos
);

   logic [HASH_BITS-1:0] min_hash_ff, min_hash_in;
   logic [POS_BITS-1:0]  min_pos_ff, min_pos_in;
   logic [HASH_BITS-1:0] base_hash;
   logic [POS_BITS-1:0]  base_pos;
   logic                 less;
   logic                 update;

   // compare and select
   always_comb begin
      base_hash   = ctl.clear ? '0 : min_hash_ff;
      base_pos    = ctl.clear ? '0 : min_pos_ff;
      less        = cand_hash < base_hash;
      update      = ctl.take & (ctl.force_load | less);
      min_hash_in = update ? cand_hash : base_hash;
      min_pos_in  = update ? cand_pos  : base_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_hash_ff <= '0;
         min_pos_ff  <= '0;
      end else begin
         min_hash_ff <= min_hash_in;
         min_pos_ff  <= min_pos_in;
      end
   end

   assign min_hash  = min_hash_ff;
   assign min_pos   = min_pos_ff;
   assign next_hash = min_hash_in;
   assign next_pos  = min_pos_in;

endmodule

/* src/wfs_checker.sv */
// -----------------------------------------------------------------------------
// wfs_checker
// Port-level checks of the winnowing fingerprint selector, bound to the top.
// -----------------------------------------------------------------------------
`include "winnowing_fingerprint_selector_assert.svh"

module wfs_checker import wfs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input wfs_rsp_type rsp_data
);

   // a stalled result holds
   `WFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a blocked result register blocks the input side
   `WFS_ASSERT_SAME(a_req_blocked, rsp_valid && rsp_stall, req_stall)

   // a new result follows an input transfer or the end of a rescan
   `WFS_ASSERT_SAME(a_rsp_cause, $rose(rsp_valid),
                    $past(req_valid && !req_stall) || $past(req_stall))

   // no result straight out of reset
   `WFS_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind winnowing_fingerprint_selector wfs_checker u_wfs_checker (.*);
